FILE: rtl/core/mte_pkg.sv
// mte_pkg: shared widths, constants, codes and structs of the multiturn encoder tracker
// depends on nothing; every other file refers to it by scoped names
`timescale 1ns / 1ps

package mte_pkg;

  localparam int ANG_W   = 12;
  localparam int RAW_W   = 16;
  localparam int POS_W   = 28;
  localparam int DELTA_W = ANG_W + 1;
  localparam int MIX_W   = 32;
  localparam int PROD_W  = 2 * MIX_W;

  // one turn is 2**ANG_W counts; jumps beyond WRAP_LIMIT count as a wrap
  localparam int WRAP_LIMIT = 4076;

  // signed divide by ten: high part of n * RECIP10, shifted, plus one when n < 0
  localparam logic signed [MIX_W-1:0] RECIP10 = 32'sh66666667;
  localparam int RECIP_SHIFT = 34;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  // action codes
  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_HOME = 1'b1;

  // register indexes (byte address bit 2)
  localparam logic REG_REVERSE   = 1'b0;
  localparam logic REG_REFERENCE = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_HOME   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    logic             reverse;
    logic [ANG_W-1:0] reference;
  } cfg_t;

  typedef struct packed {
    logic             action;
    logic [RAW_W-1:0] raw_word;
    logic             bus_error;
  } in_item_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [POS_W-1:0] pos;
    logic                    err;
  } trk_res_t;

endpackage

FILE: rtl/core/mte_if.sv
// mte_if: valid/ready channel interfaces for sensor items and tracker results
// depends on mte_pkg for field widths
`timescale 1ns / 1ps

interface mte_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [mte_pkg::RAW_W-1:0]   raw_word;
  logic                        bus_error;

  modport source (output valid, output action, output raw_word, output bus_error,
                  input ready);
  modport sink   (input valid, input action, input raw_word, input bus_error,
                  output ready);
endinterface

interface mte_out_if;
  logic                               valid;
  logic                               ready;
  logic                               accepted;
  logic signed [mte_pkg::POS_W-1:0]   position;
  logic signed [mte_pkg::POS_W-1:0]   filtered_position;
  logic                               error_flag;

  modport source (output valid, output accepted, output position,
                  output filtered_position, output error_flag, input ready);
  modport sink   (input valid, input accepted, input position,
                  input filtered_position, input error_flag, output ready);
endinterface

FILE: rtl/core/mte_cfg.sv
// mte_cfg: apb-style register file holding direction and reference angle
// depends on mte_pkg for cfg_t and register indexes
`timescale 1ns / 1ps

module mte_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mte_pkg::CFG_AW-1:0]    paddr,
  input  logic [mte_pkg::CFG_DW-1:0]    pwdata,
  output logic [mte_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output mte_pkg::cfg_t                 cfg
);

  mte_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        mte_pkg::REG_REVERSE:   cfg_r.reverse   <= pwdata[0];
        mte_pkg::REG_REFERENCE: cfg_r.reference <= pwdata[mte_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mte_pkg::REG_REVERSE:   prdata = {{(mte_pkg::CFG_DW-1){1'b0}}, cfg_r.reverse};
      mte_pkg::REG_REFERENCE: prdata = {{(mte_pkg::CFG_DW-mte_pkg::ANG_W){1'b0}},
                                        cfg_r.reference};
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/mte_track.sv
// mte_track: angle unwrap stage; holds stored angle, previous angle, turns, error flag
// depends on mte_pkg for cfg_t, in_item_t, trk_res_t and constants
`timescale 1ns / 1ps

module mte_track #(
  parameter int TURN_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mte_pkg::cfg_t        cfg,
  input  mte_pkg::in_item_t    item,
  input  logic                 adv,
  output mte_pkg::trk_res_t    res
);

  localparam int ANG_W   = mte_pkg::ANG_W;
  localparam int POS_W   = mte_pkg::POS_W;
  localparam int DELTA_W = mte_pkg::DELTA_W;
  localparam logic signed [DELTA_W-1:0] LIM_P = DELTA_W'(mte_pkg::WRAP_LIMIT);
  localparam logic signed [DELTA_W-1:0] LIM_N = -LIM_P;

  logic [ANG_W-1:0]     stored_r, stored_nxt;
  logic [ANG_W-1:0]     prev_r, prev_nxt;
  logic [TURN_BITS-1:0] turn_r, turn_nxt;
  logic                 err_r, err_nxt;

  logic [ANG_W-1:0]          value;
  logic [ANG_W-1:0]          new_ang;
  logic signed [DELTA_W-1:0] delta;
  logic                      bad;
  logic [POS_W-1:0]          turn_ext;

  always_comb begin
    value    = cfg.reverse ? ~item.raw_word[ANG_W-1:0] : item.raw_word[ANG_W-1:0];
    bad      = item.bus_error || (item.raw_word[mte_pkg::RAW_W-1:ANG_W] != '0);
    new_ang  = value - cfg.reference;
    delta    = $signed({1'b0, new_ang}) - $signed({1'b0, prev_r});

    stored_nxt = stored_r;
    prev_nxt   = prev_r;
    turn_nxt   = turn_r;
    err_nxt    = err_r;
    res.kind   = mte_pkg::KIND_READ;

    if (item.action == mte_pkg::ACT_HOME) begin
      res.kind = mte_pkg::KIND_HOME;
      turn_nxt = '0;
      prev_nxt = stored_r - cfg.reference;
    end else if (bad) begin
      res.kind = mte_pkg::KIND_REJECT;
      err_nxt  = 1'b1;
    end else begin
      stored_nxt = value;
      err_nxt    = 1'b0;
      prev_nxt   = new_ang;
      if (delta > LIM_P) begin
        turn_nxt = turn_r - TURN_BITS'(1);
      end else if (delta < LIM_N) begin
        turn_nxt = turn_r + TURN_BITS'(1);
      end
    end

    // turns sign-extended, then shifted up by one turn
    turn_ext = {{(POS_W-TURN_BITS){turn_nxt[TURN_BITS-1]}}, turn_nxt};
    res.pos  = $signed({turn_ext[POS_W-ANG_W-1:0], prev_nxt});
    res.err  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
      prev_r   <= '0;
      turn_r   <= '0;
      err_r    <= 1'b0;
    end else if (adv) begin
      stored_r <= stored_nxt;
      prev_r   <= prev_nxt;
      turn_r   <= turn_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

FILE: rtl/core/mte_filter.sv
// mte_filter: iir stage (8*pos + 2*acc) / 10 toward zero, holds the filter accumulator
// depends on mte_pkg for trk_res_t, reciprocal constant and widths
`timescale 1ns / 1ps

module mte_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mte_pkg::trk_res_t                 res,
  input  logic                              adv,
  output logic signed [mte_pkg::POS_W-1:0]  filt
);

  localparam int POS_W  = mte_pkg::POS_W;
  localparam int MIX_W  = mte_pkg::MIX_W;
  localparam int PROD_W = mte_pkg::PROD_W;
  localparam int SH     = mte_pkg::RECIP_SHIFT;

  logic signed [POS_W-1:0]  acc_r;
  logic signed [MIX_W-1:0]  pos_x, acc_x, mix;
  logic signed [PROD_W-1:0] prod;
  logic [POS_W-1:0]         quot;

  always_comb begin
    pos_x = MIX_W'(res.pos);
    acc_x = MIX_W'(acc_r);
    mix   = (pos_x <<< 3) + (acc_x <<< 1);
    prod  = PROD_W'(mix) * PROD_W'(mte_pkg::RECIP10);
    // floor of the product, bumped by one for negative sums gives truncation
    quot  = prod[SH+POS_W-1:SH] + POS_W'(mix[MIX_W-1]);

    case (res.kind)
      mte_pkg::KIND_HOME:   filt = res.pos;
      mte_pkg::KIND_REJECT: filt = acc_r;
      mte_pkg::KIND_READ:   filt = $signed(quot);
      default:              filt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv) begin
      acc_r <= filt;
    end
  end

endmodule

FILE: rtl/core/multiturn_encoder_tracker.sv
// multiturn_encoder_tracker: top level; input register, unwrap stage, filter stage,
// output register and apb-style configuration; depends on mte_pkg, mte_if,
// mte_cfg, mte_track and mte_filter
//
//   port group | direction | handshake          | contents
//   in_ch      | sink      | valid / ready      | action, raw_word, bus_error
//   out_ch     | source    | valid / ready      | accepted, position, filtered_position,
//              |           |                    | error_flag
//   apb        | slave     | psel, penable      | reverse_direction @0x0, reference_angle @0x4
//
// one item per cycle sustained while out_ch.ready holds; an accepted item passes the input
// register (stage a), then the unwrap stage register (stage b), then the result register,
// from which it can leave
// the filter accumulator loop (one signed 32x32 reciprocal multiply) sets the clock path
// rst_n is synchronous, active low, and clears all tracker state, the filter and config
// a stalled output only blocks the stages behind it once they are full; empty
// stages keep taking items
`timescale 1ns / 1ps

module multiturn_encoder_tracker #(
  parameter int TURN_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mte_in_if.sink                        in_ch,
  mte_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mte_pkg::CFG_AW-1:0]    paddr,
  input  logic [mte_pkg::CFG_DW-1:0]    pwdata,
  output logic [mte_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  mte_pkg::cfg_t cfg;

  // stage a: raw item as accepted
  logic               a_valid_r;
  mte_pkg::in_item_t  a_item_r;
  mte_pkg::in_item_t  in_item;

  // stage b: unwrapped position and item kind
  logic               b_valid_r;
  mte_pkg::trk_res_t  b_res_r;
  mte_pkg::trk_res_t  trk_res;

  // output register
  logic                              out_valid_r;
  logic                              out_acc_r;
  logic signed [mte_pkg::POS_W-1:0]  out_pos_r;
  logic signed [mte_pkg::POS_W-1:0]  out_filt_r;
  logic                              out_err_r;
  logic signed [mte_pkg::POS_W-1:0]  filt;

  // stage enables: a stage moves when it is empty or the one after it moves
  logic en_out, en_b, en_a;
  logic adv_a, adv_b;

  assign en_out = !out_valid_r || out_ch.ready;
  assign en_b   = !b_valid_r || en_out;
  assign en_a   = !a_valid_r || en_b;
  assign adv_a  = a_valid_r && en_b;
  assign adv_b  = b_valid_r && en_out;

  assign in_ch.ready = en_a;

  assign in_item.action    = in_ch.action;
  assign in_item.raw_word  = in_ch.raw_word;
  assign in_item.bus_error = in_ch.bus_error;

  mte_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // unwrap state commits when the stage a item moves into stage b
  mte_track #(
    .TURN_BITS (TURN_BITS)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (a_item_r),
    .adv   (adv_a),
    .res   (trk_res)
  );

  // filter accumulator commits when the stage b item moves into the output register
  mte_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .res   (b_res_r),
    .adv   (adv_b),
    .filt  (filt)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a)   a_valid_r   <= in_ch.valid;
      if (en_b)   b_valid_r   <= a_valid_r;
      if (en_out) out_valid_r <= b_valid_r;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_item_r <= in_item;
    end
    if (en_b) begin
      b_res_r <= trk_res;
    end
    if (en_out) begin
      out_acc_r  <= (b_res_r.kind != mte_pkg::KIND_REJECT);
      out_pos_r  <= b_res_r.pos;
      out_filt_r <= filt;
      out_err_r  <= b_res_r.err;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.accepted          = out_acc_r;
  assign out_ch.position          = out_pos_r;
  assign out_ch.filtered_position = out_filt_r;
  assign out_ch.error_flag        = out_err_r;

  // a rejected read always leaves the sticky error set
  a_reject_sets_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_acc_r || out_err_r))
    else $error("rejected item without error flag");

  // with every stage full and the output stalled, no item may enter
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && b_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline is full");

  // an item leaving stage b lands in the output register
  a_b_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv_b |=> out_valid_r)
    else $error("stage b item lost");

  // a home result reports identical raw and filtered positions
  a_home_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_b && b_res_r.kind == mte_pkg::KIND_HOME) |=> (out_pos_r == out_filt_r))
    else $error("home result positions differ");

endmodule

FILE: sim/mte_score_pkg.sv
// mte_score_pkg: scoreboard class that predicts tracker results and checks the output items
// depends on mte_pkg for widths, action codes and register indexes
`timescale 1ns / 1ps

package mte_score_pkg;

  localparam int TURN_W = mte_pkg::POS_W - mte_pkg::ANG_W;
  localparam logic [mte_pkg::RAW_W-1:0] SENSOR_MAX = 16'd4095;

  typedef struct packed {
    logic                             accepted;
    logic signed [mte_pkg::POS_W-1:0] position;
    logic signed [mte_pkg::POS_W-1:0] filtered;
    logic                             error_flag;
  } track_out_t;

  class track_scoreboard;
    logic                             reverse;
    logic [mte_pkg::ANG_W-1:0]        zero_angle;
    logic [mte_pkg::ANG_W-1:0]        raw_angle;
    logic [mte_pkg::ANG_W-1:0]        last_angle;
    logic [TURN_W-1:0]                turns;
    logic signed [mte_pkg::POS_W-1:0] filt;
    logic                             err_sticky;
    track_out_t                       due_outputs[$];
    int                               faults;

    function new();
      reverse = 1'b0;
      zero_angle = '0;
      raw_angle = '0;
      last_angle = '0;
      turns = '0;
      filt = '0;
      err_sticky = 1'b0;
      faults = 0;
    endfunction

    function void set_reg(logic idx, logic [mte_pkg::CFG_DW-1:0] value);
      if (idx == mte_pkg::REG_REVERSE) begin
        reverse = value[0];
      end else begin
        zero_angle = value[mte_pkg::ANG_W-1:0];
      end
    endfunction

    // turns and angle side by side fill the position width exactly
    function logic signed [mte_pkg::POS_W-1:0] here();
      return signed'({turns, last_angle});
    endfunction

    function void log_item(logic action, logic [mte_pkg::RAW_W-1:0] raw, logic berr);
      track_out_t                want;
      logic [mte_pkg::ANG_W-1:0] ang;
      int                        jump;
      longint                    mix;
      want.accepted = 1'b0;
      if (action == mte_pkg::ACT_HOME) begin
        turns = '0;
        last_angle = raw_angle - zero_angle;
        filt = here();
        want.accepted = 1'b1;
      end else if (berr || raw > SENSOR_MAX) begin
        err_sticky = 1'b1;
      end else begin
        raw_angle = reverse ? (12'hFFF - raw[mte_pkg::ANG_W-1:0])
                            : raw[mte_pkg::ANG_W-1:0];
        err_sticky = 1'b0;
        ang = raw_angle - zero_angle;
        jump = int'(ang) - int'(last_angle);
        if (jump > mte_pkg::WRAP_LIMIT) begin
          turns = turns - 1'b1;
        end else if (jump < -mte_pkg::WRAP_LIMIT) begin
          turns = turns + 1'b1;
        end
        last_angle = ang;
        mix = 8 * longint'(here()) + 2 * longint'(filt);
        filt = mte_pkg::POS_W'(mix / 10);
        want.accepted = 1'b1;
      end
      want.position = here();
      want.filtered = filt;
      want.error_flag = err_sticky;
      due_outputs.push_back(want);
    endfunction

    function void check_result(logic acc, logic signed [mte_pkg::POS_W-1:0] pos,
                               logic signed [mte_pkg::POS_W-1:0] fpos, logic err);
      track_out_t want;
      if (due_outputs.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected result: acc=%0b pos=%0d filt=%0d err=%0b",
                   acc, pos, fpos, err);
        end
        return;
      end
      want = due_outputs.pop_front();
      if (want.accepted !== acc || want.position !== pos || want.filtered !== fpos ||
          want.error_flag !== err) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch: expected acc=%0b pos=%0d filt=%0d err=%0b, %s",
                   want.accepted, want.position, want.filtered, want.error_flag,
                   $sformatf("got acc=%0b pos=%0d filt=%0d err=%0b", acc, pos, fpos, err));
        end
      end
    endfunction

    function int pending();
      return due_outputs.size();
    endfunction
  endclass

endpackage

FILE: sim/tb_multiturn_encoder_tracker.sv
// tb_multiturn_encoder_tracker: drives sensor reads and home commands into the tracker,
// checks every result against the scoreboard; depends on mte_pkg, mte_if, mte_score_pkg
// and the multiturn_encoder_tracker rtl
`timescale 1ns / 1ps

module tb_multiturn_encoder_tracker;

  localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake before giving up
  localparam int SETTLE       = 4;      // pipeline depth plus margin
  localparam int PHASE_ITEMS  = 200;
  localparam int SPIN_TURNS   = 20;     // a run of whole turns forward
  localparam int HOLD_CYCLES  = 80;

  logic clk = 1'b0;
  logic rst_n;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [mte_pkg::CFG_AW-1:0] paddr;
  logic [mte_pkg::CFG_DW-1:0] pwdata;
  logic [mte_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  mte_in_if  in_ch ();
  mte_out_if out_ch ();

  multiturn_encoder_tracker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mte_score_pkg::track_scoreboard track_sb = new();

  // sender state
  int unsigned               burst_left = 0;
  logic [mte_pkg::ANG_W-1:0] last_raw = '0;

  // receiver state
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned stall_mode = 0;
  int unsigned idle_run = 0;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // result side: check each result taken, then pick ready for the next edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      track_sb.check_result(out_ch.accepted, out_ch.position, out_ch.filtered_position,
                            out_ch.error_flag);
      results_seen++;
      // long hold-offs so the pipeline fills and the input stalls
      if (results_seen == 300 || results_seen == 700) begin
        hold_left = HOLD_CYCLES;
      end
    end
    rx_cycle++;
    if (rx_cycle % 64 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (rx_cycle % 8 != 5);
      endcase
    end
  end

  // watchdog: any handshake or register access counts as progress
  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------------

  // offer one item, note it once taken, then maybe go quiet for a while
  task automatic send_item(input logic act, input logic [mte_pkg::RAW_W-1:0] raw,
                           input logic berr);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.raw_word  <= raw;
    in_ch.bus_error <= berr;
    do @(posedge clk); while (!in_ch.ready);
    track_sb.log_item(act, raw, berr);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_ch.valid     <= 1'b0;
      in_ch.action    <= 1'($urandom);
      in_ch.raw_word  <= 16'($urandom);
      in_ch.bus_error <= 1'($urandom);
      repeat (gap) @(posedge clk);
      // now and then a long unbroken burst
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic send_read(input logic [mte_pkg::RAW_W-1:0] raw, input logic berr);
    send_item(mte_pkg::ACT_READ, raw, berr);
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (track_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup phase, access phase, then a quiet phase so writes never overlap
  task automatic reg_write(input logic idx, input logic [mte_pkg::CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    track_sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_mode(input logic rev, input logic [mte_pkg::ANG_W-1:0] zero);
    drain();
    reg_write(mte_pkg::REG_REVERSE, mte_pkg::CFG_DW'(rev));
    reg_write(mte_pkg::REG_REFERENCE, mte_pkg::CFG_DW'(zero));
  endtask

  // mostly plausible motion with small steps across the wrap point, plus noise
  task automatic run_random(input int count);
    int pick;
    int step;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        step = int'($urandom_range(0, 38)) - 19;
        last_raw = last_raw + mte_pkg::ANG_W'(step);
        send_read({4'b0, last_raw}, 1'b0);
      end else if (pick < 62) begin
        step = int'($urandom_range(0, 600)) - 300;
        last_raw = last_raw + mte_pkg::ANG_W'(step);
        send_read({4'b0, last_raw}, 1'b0);
      end else if (pick < 75) begin
        last_raw = mte_pkg::ANG_W'($urandom_range(0, 4095));
        send_read({4'b0, last_raw}, 1'b0);
      end else if (pick < 84) begin
        // failed bus transaction, any data
        send_read(mte_pkg::RAW_W'($urandom_range(0, 65535)), 1'b1);
      end else if (pick < 93) begin
        // out-of-range word with a clean bus
        send_read(mte_pkg::RAW_W'($urandom_range(4096, 65535)), 1'b0);
      end else begin
        send_item(mte_pkg::ACT_HOME, mte_pkg::RAW_W'($urandom), 1'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.action    = mte_pkg::ACT_READ;
    in_ch.raw_word  = '0;
    in_ch.bus_error = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain mode, wrap thresholds and rejects
    set_mode(1'b0, 12'd0);
    send_read(16'd0, 1'b0);
    send_read(16'd4095, 1'b0);     // jump down through zero
    send_read(16'd0, 1'b0);        // and back up
    send_read(16'd4076, 1'b0);     // exactly at the limit, no wrap
    send_read(16'd0, 1'b0);
    send_read(16'd4077, 1'b0);     // one past the limit
    send_read(16'd0, 1'b0);
    send_read(16'd4096, 1'b0);     // first word out of range
    send_read(16'hFFFF, 1'b0);
    send_read(16'd4095, 1'b1);     // bus error on an in-range word
    send_read(16'd100, 1'b0);      // clean read clears the flag
    send_item(mte_pkg::ACT_HOME, 16'hFFFF, 1'b1);
    send_read(16'h8000, 1'b0);
    send_read(16'h0AAA, 1'b0);
    send_read(16'h0555, 1'b0);

    // directed: mirrored with the largest offset
    set_mode(1'b1, 12'd4095);
    send_read(16'd0, 1'b0);
    send_read(16'd4095, 1'b0);
    send_item(mte_pkg::ACT_HOME, 16'd0, 1'b0);
    send_read(16'd2048, 1'b0);

    // directed: offset pushes the angle below zero
    set_mode(1'b0, 12'd1);
    send_read(16'd0, 1'b0);
    send_item(mte_pkg::ACT_HOME, 16'd1234, 1'b0);
    send_read(16'd4095, 1'b0);

    // random phases under several register settings
    set_mode(1'b0, 12'd0);
    run_random(PHASE_ITEMS);
    set_mode(1'b1, 12'd4095);
    run_random(PHASE_ITEMS);
    set_mode(1'($urandom), mte_pkg::ANG_W'($urandom));
    run_random(PHASE_ITEMS);
    set_mode(1'b1, mte_pkg::ANG_W'($urandom_range(0, 4095)));
    run_random(PHASE_ITEMS);

    // spin forward through several whole turns
    set_mode(1'b0, 12'd0);
    send_item(mte_pkg::ACT_HOME, 16'd0, 1'b0);
    for (int t = 0; t < SPIN_TURNS; t++) begin
      send_read(16'd0, 1'b0);
      send_read(16'd2000, 1'b0);
      send_read(16'd4095, 1'b0);
    end
    run_random(40);

    drain();
    repeat (SETTLE * 2) @(posedge clk);
    if (track_sb.faults == 0 && track_sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/mte_pkg.sv
rtl/core/mte_if.sv
rtl/core/mte_cfg.sv
rtl/core/mte_track.sv
rtl/core/mte_filter.sv
rtl/core/multiturn_encoder_tracker.sv
sim/mte_score_pkg.sv
sim/tb_multiturn_encoder_tracker.sv
